[rtl/lfsc_pkg.sv]
// Shared types and constants for the line-follow steering control block.
// Holds the request, response and configuration structs, register indexes
// and the fixed-point coefficients. No dependencies.
package lfsc_pkg;

   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;
   localparam int MulW     = 32;
   localparam int ProdW    = 64;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] line_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_velocity;
      logic signed [15:0] right_velocity;
   } rsp_type;

   typedef struct packed {
      logic [15:0] target_speed;
      logic [15:0] max_wheel_velocity;
      logic [15:0] turn_scale;
      logic        reverse_direction;
   } cfg_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_TARGET_SPEED  = 2'd0,
      CSR_MAX_WHEEL_VEL = 2'd1,
      CSR_TURN_SCALE    = 2'd2,
      CSR_REVERSE_DIR   = 2'd3
   } csr_index_type;

   // input kinds
   localparam logic KIND_DRIVE = 1'b0;
   localparam logic KIND_STOP  = 1'b1;

   // register reset values
   localparam logic [15:0] TARGET_SPEED_RST = 16'd16384;
   localparam logic [15:0] MAX_WHEEL_VEL_RST = 16'd2048;
   localparam logic [15:0] TURN_SCALE_RST   = 16'd552;
   localparam logic        REVERSE_DIR_RST  = 1'b1;

   // filter coefficients, scale 2^-16
   localparam logic [15:0] ALPHA_03 = 16'd19661;
   localparam logic [15:0] ALPHA_01 = 16'd6554;

   // thresholds
   localparam logic signed [24:0] SMALL_ANGLE = 25'sd104858;
   localparam logic signed [24:0] NEAR_SPEED  = 25'sd6554;

   // steering gain in halves
   localparam logic [3:0] GAIN_SMALL = 4'd3;
   localparam logic [3:0] GAIN_LARGE = 4'd10;

   // 1/(2 pi) at scale 2^-32
   localparam logic signed [MulW-1:0] INV_TWO_PI = 32'sd683565276;

endpackage

[rtl/lfsc_mul.sv]
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Uses lfsc_pkg for operand and product widths.
module lfsc_mul (
   input  logic                                clock,
   input  logic signed [lfsc_pkg::MulW-1:0]    op_a,
   input  logic signed [lfsc_pkg::MulW-1:0]    op_b,
   output logic signed [lfsc_pkg::ProdW-1:0]   prod
);
   import lfsc_pkg::*;

   logic signed [ProdW-1:0] prod_ff;
   logic signed [ProdW-1:0] prod_in;

   assign prod_in = ProdW'(op_a) * ProdW'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

[rtl/lfsc_csr.sv]
// Configuration registers of the steering block, written through a plain
// write port. Uses lfsc_pkg for the register struct and indexes.
module lfsc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [lfsc_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [lfsc_pkg::CsrDataW-1:0]    csr_wdata,
   output lfsc_pkg::cfg_type                cfg
);
   import lfsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TARGET_SPEED:  cfg_in.target_speed       = csr_wdata;
            CSR_MAX_WHEEL_VEL: cfg_in.max_wheel_velocity = csr_wdata;
            CSR_TURN_SCALE:    cfg_in.turn_scale         = csr_wdata;
            CSR_REVERSE_DIR:   cfg_in.reverse_direction  = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_speed       <= TARGET_SPEED_RST;
         cfg_ff.max_wheel_velocity <= MAX_WHEEL_VEL_RST;
         cfg_ff.turn_scale         <= TURN_SCALE_RST;
         cfg_ff.reverse_direction  <= REVERSE_DIR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/line_follow_steering_control.sv]
// Top level of the line-follow steering control: sequencer, filter state and
// output register. Depends on lfsc_pkg, lfsc_csr and lfsc_mul.
//
// Usage:
//   req_* carries one control tick: kind selects a drive step (line_angle
//   used) or a stop command. rsp_* returns one item per tick with both wheel
//   velocities in signed Q8.8 rotations per second, saturated.
//   csr_* writes target_speed, max_wheel_velocity, turn_scale and
//   reverse_direction; write only while no tick is in flight.
// Sequencing:
//   A drive step makes seven passes through the one shared 32x32 multiplier
//   under a one-hot sequencer; a stop goes straight to the output state.
//   req_ready is high only while the sequencer idles, so one tick is in
//   flight at a time: no new tick is taken until the current one is handed
//   to the output register, including any wait for that register.
// Reset:
//   Registers return to their reset values, filters clear to zero, no ramp
//   restart is pending and rsp_valid drops.
// Stall:
//   The finished item waits in the output register; the sequencer holds in
//   its last state until that register is free, so nothing is lost.
module line_follow_steering_control (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  lfsc_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output lfsc_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [lfsc_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [lfsc_pkg::CsrDataW-1:0]    csr_wdata
);
   import lfsc_pkg::*;

   typedef enum logic [15:0] {
      ST_IDLE  = 16'h0001,
      ST_AMUL  = 16'h0002,
      ST_AUPD  = 16'h0004,
      ST_GAIN  = 16'h0008,
      ST_SSEL  = 16'h0010,
      ST_GMUL  = 16'h0020,
      ST_TMUL  = 16'h0040,
      ST_SMUL  = 16'h0080,
      ST_SUPD  = 16'h0100,
      ST_FMUL  = 16'h0200,
      ST_WSUM  = 16'h0400,
      ST_RND   = 16'h0800,
      ST_O0MUL = 16'h1000,
      ST_O1MUL = 16'h2000,
      ST_O1FIN = 16'h4000,
      ST_OUT   = 16'h8000
   } state_type;

   localparam logic signed [ProdW-1:0] RND16 = 64'sd32768;
   localparam logic signed [ProdW-1:0] RND40 = 64'sd549755813888;
   localparam logic signed [45:0]      RND13 = 46'sd4096;

   function automatic logic signed [15:0] sat_q88(input logic signed [ProdW-1:0] p);
      logic signed [ProdW-1:0] q;
      q = (p + RND40) >>> 40;
      if (q > 64'sd32767) begin
         return 16'sh7FFF;
      end else if (q < -64'sd32768) begin
         return 16'sh8000;
      end
      return q[15:0];
   endfunction

   cfg_type cfg;

   lfsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   logic signed [MulW-1:0]  op_a;
   logic signed [MulW-1:0]  op_b;
   logic signed [ProdW-1:0] prod;

   lfsc_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   state_type          state_ff, state_in;
   logic signed [23:0] fa_ff, fa_in;
   logic [16:0]        fs_ff, fs_in;
   logic               pend_ff, pend_in;
   logic signed [24:0] diff_ff, diff_in;
   logic [3:0]         gain_ff, gain_in;
   logic [15:0]        alpha_ff, alpha_in;
   logic signed [43:0] turn_ff, turn_in;
   logic signed [45:0] v0_ff, v0_in, v1_ff, v1_in;
   logic signed [31:0] r0_ff, r0_in, r1_ff, r1_in;
   logic signed [15:0] out0_ff, out0_in, out1_ff, out1_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_fire;
   logic               out_free;
   logic signed [ProdW-1:0] rnd16;
   logic signed [25:0] fa_sum;
   logic signed [19:0] fs_sum;
   logic signed [24:0] fa_mag;
   logic signed [24:0] diff_mag;
   logic [16:0]        fs_base;
   logic signed [45:0] fwd_w, turn_w, sf, st;
   logic signed [45:0] v0_rnd, v1_rnd;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rnd16    = (prod + RND16) >>> 16;
   assign fa_sum   = 26'(fa_ff) + $signed(rnd16[25:0]);
   assign fs_sum   = $signed({3'b000, fs_ff}) + $signed(rnd16[19:0]);
   assign fa_mag   = fa_ff[23] ? -25'(fa_ff) : 25'(fa_ff);
   assign diff_mag = diff_ff[24] ? -diff_ff : diff_ff;
   assign fs_base  = pend_ff ? 17'd0 : fs_ff;

   assign fwd_w  = {7'b0000000, prod[33:0], 5'b00000};
   assign turn_w = 46'(turn_ff);
   assign sf     = cfg.reverse_direction ? -fwd_w : fwd_w;
   assign st     = cfg.reverse_direction ? -turn_w : turn_w;
   assign v0_rnd = (v0_ff + RND13) >>> 13;
   assign v1_rnd = (v1_ff + RND13) >>> 13;

   // operand select for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_AMUL: begin
            op_a = 32'(diff_ff);
            op_b = $signed({16'd0, ALPHA_03});
         end
         ST_GMUL: begin
            op_a = 32'(fa_ff);
            op_b = $signed({28'd0, gain_ff});
         end
         ST_TMUL: begin
            op_a = prod[31:0];
            op_b = $signed({16'd0, cfg.turn_scale});
         end
         ST_SMUL: begin
            op_a = 32'(diff_ff);
            op_b = $signed({16'd0, alpha_ff});
         end
         ST_FMUL: begin
            op_a = $signed({15'd0, fs_ff});
            op_b = $signed({16'd0, cfg.max_wheel_velocity});
         end
         ST_O0MUL: begin
            op_a = r0_ff;
            op_b = INV_TWO_PI;
         end
         ST_O1MUL: begin
            op_a = r1_ff;
            op_b = INV_TWO_PI;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      fa_in        = fa_ff;
      fs_in        = fs_ff;
      pend_in      = pend_ff;
      diff_in      = diff_ff;
      gain_in      = gain_ff;
      alpha_in     = alpha_ff;
      turn_in      = turn_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      out0_in      = out0_ff;
      out1_in      = out1_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.kind == KIND_STOP) begin
                  pend_in  = 1'b1;
                  out0_in  = '0;
                  out1_in  = '0;
                  state_in = ST_OUT;
               end else begin
                  diff_in  = 25'($signed({req_data.line_angle, 8'd0})) - 25'(fa_ff);
                  state_in = ST_AMUL;
               end
            end
         end
         ST_AMUL: state_in = ST_AUPD;
         ST_AUPD: begin
            if (fa_sum > 26'sd8388607) begin
               fa_in = 24'sh7FFFFF;
            end else if (fa_sum < -26'sd8388608) begin
               fa_in = 24'sh800000;
            end else begin
               fa_in = fa_sum[23:0];
            end
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            gain_in  = (fa_mag < SMALL_ANGLE) ? GAIN_SMALL : GAIN_LARGE;
            // a stop since the last drive step restarts the ramp from zero
            fs_in    = fs_base;
            pend_in  = 1'b0;
            diff_in  = $signed({8'd0, cfg.target_speed, 1'b0}) - $signed({8'd0, fs_base});
            state_in = ST_SSEL;
         end
         ST_SSEL: begin
            alpha_in = (diff_mag < NEAR_SPEED) ? ALPHA_03 : ALPHA_01;
            state_in = ST_GMUL;
         end
         ST_GMUL: state_in = ST_TMUL;
         ST_TMUL: state_in = ST_SMUL;
         ST_SMUL: begin
            turn_in  = prod[43:0];
            state_in = ST_SUPD;
         end
         ST_SUPD: begin
            if (fs_sum < 20'sd0) begin
               fs_in = 17'd0;
            end else if (fs_sum > 20'sd131071) begin
               fs_in = 17'd131071;
            end else begin
               fs_in = fs_sum[16:0];
            end
            state_in = ST_FMUL;
         end
         ST_FMUL: state_in = ST_WSUM;
         ST_WSUM: begin
            // direction applied here; the second wheel is negated
            v0_in    = sf - st;
            v1_in    = -sf - st;
            state_in = ST_RND;
         end
         ST_RND: begin
            r0_in    = v0_rnd[31:0];
            r1_in    = v1_rnd[31:0];
            state_in = ST_O0MUL;
         end
         ST_O0MUL: state_in = ST_O1MUL;
         ST_O1MUL: begin
            out0_in  = sat_q88(prod);
            state_in = ST_O1FIN;
         end
         ST_O1FIN: begin
            out1_in  = sat_q88(prod);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_in.left_velocity  = out0_ff;
               rsp_in.right_velocity = out1_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fa_ff        <= '0;
         fs_ff        <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fa_ff        <= fa_in;
         fs_ff        <= fs_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      gain_ff  <= gain_in;
      alpha_ff <= alpha_in;
      turn_ff  <= turn_in;
      v0_ff    <= v0_in;
      v1_ff    <= v1_in;
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      out0_ff  <= out0_in;
      out1_ff  <= out1_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[dv/line_follow_steering_control_tb.sv]
// Self-checking testbench for line_follow_steering_control: directed ticks from a table,
// then random phases with register changes, checked against an in-bench steering predictor.
// Depends on lfsc_pkg and the block's RTL.
module line_follow_steering_control_tb;
   import lfsc_pkg::*;

   localparam longint AlphaFast  = 19661;
   localparam longint AlphaSlow  = 6554;
   localparam longint SmallAngle = 104858;
   localparam longint NearSpeed  = 6554;
   localparam longint InvTwoPi   = 683565276;
   localparam longint AngleMax   = 8388607;
   localparam longint AngleMin   = -8388608;
   localparam longint SpeedMax   = 131071;
   localparam longint RateClamp  = 64'sd8589934592;
   localparam int     QuietLimit = 4000;
   localparam int     PhaseCount = 7;
   localparam int     PhaseItems = 100;

   typedef struct {
      bit            is_write;
      csr_index_type reg_idx;
      logic [15:0]   reg_val;
      req_type       tick;
      bit            typed;
      rsp_type       want;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   // predictor state and register copies
   longint  angle_state = 0;
   longint  speed_state = 0;
   bit      restart_state = 1'b0;
   longint  cfg_target = 16384;
   longint  cfg_maxvel = 2048;
   longint  cfg_turn = 552;
   bit      cfg_reverse = 1'b1;

   rsp_type pending_wheels[$];
   plan_row_type plan[$];
   int      mismatches = 0;
   int      quiet_cycles = 0;
   int      walk_angle = 0;
   bit      steady = 1'b0;

   line_follow_steering_control i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // round half up, then shift right
   function automatic longint round_shift(longint v, int n);
      longint t;
      t = v + (longint'(1) <<< (n - 1));
      return t >>> n;
   endfunction

   function automatic logic signed [15:0] rate_to_q88(longint w);
      longint r;
      longint q;
      r = round_shift(w, 13);
      // clip far out of range rates; the result saturates either way
      if (r > RateClamp) r = RateClamp;
      if (r < -RateClamp) r = -RateClamp;
      q = round_shift(r * InvTwoPi, 40);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic rsp_type predict_wheels(req_type it);
      rsp_type o;
      longint  ang, diff, mag, fa, fs, fwd, turn, w0, w1, gain, alpha;
      o = '0;
      if (it.kind == KIND_STOP) begin
         restart_state = 1'b1;
         return o;
      end
      ang = longint'($signed(it.line_angle));
      diff = ang * 256 - angle_state;
      fa = angle_state + round_shift(diff * AlphaFast, 16);
      if (fa > AngleMax) fa = AngleMax;
      if (fa < AngleMin) fa = AngleMin;
      angle_state = fa;
      mag = (fa < 0) ? -fa : fa;
      gain = (mag < SmallAngle) ? 3 : 10;

      if (restart_state) speed_state = 0;
      restart_state = 1'b0;
      diff = cfg_target * 2 - speed_state;
      mag = (diff < 0) ? -diff : diff;
      alpha = (mag < NearSpeed) ? AlphaFast : AlphaSlow;
      fs = speed_state + round_shift(diff * alpha, 16);
      if (fs < 0) fs = 0;
      if (fs > SpeedMax) fs = SpeedMax;
      speed_state = fs;

      fwd = fs * cfg_maxvel * 32;
      turn = fa * cfg_turn * gain;
      w0 = fwd - turn;
      w1 = fwd + turn;
      if (cfg_reverse) begin
         o.left_velocity  = rate_to_q88(-w0);
         o.right_velocity = rate_to_q88(w1);
      end else begin
         o.left_velocity  = rate_to_q88(w0);
         o.right_velocity = rate_to_q88(-w1);
      end
      return o;
   endfunction

   function automatic plan_row_type tick_row(logic kind, logic signed [15:0] ang);
      plan_row_type p;
      p = '{reg_idx: CSR_TARGET_SPEED, default: '0};
      p.tick.kind = kind;
      p.tick.line_angle = ang;
      return p;
   endfunction

   function automatic plan_row_type typed_row(logic kind, logic signed [15:0] ang,
                                              logic signed [15:0] left,
                                              logic signed [15:0] right);
      plan_row_type p;
      p = tick_row(kind, ang);
      p.typed = 1'b1;
      p.want.left_velocity = left;
      p.want.right_velocity = right;
      return p;
   endfunction

   function automatic plan_row_type write_row(csr_index_type idx, logic [15:0] val);
      plan_row_type p;
      p = '{reg_idx: CSR_TARGET_SPEED, default: '0};
      p.is_write = 1'b1;
      p.reg_idx = idx;
      p.reg_val = val;
      return p;
   endfunction

   function automatic logic [15:0] pick_scale_reg(logic [15:0] rst_val);
      case ($urandom_range(7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return rst_val;
         3: return 16'($urandom_range(65535));
         default: return 16'($urandom_range(4096));
      endcase
   endfunction

   function automatic logic signed [15:0] pick_angle();
      int          sel;
      logic [31:0] raw;
      sel = $urandom_range(99);
      if (sel < 45) begin
         // slow drift, as a real line would give
         walk_angle = walk_angle + int'($urandom_range(400)) - 200;
         if (walk_angle > 32767) walk_angle = 32767;
         if (walk_angle < -32768) walk_angle = -32768;
         return walk_angle[15:0];
      end else if (sel < 65) begin
         // around the small-angle threshold
         if ($urandom_range(1)) return 16'(-int'($urandom_range(520, 300)));
         return 16'(int'($urandom_range(520, 300)));
      end else if (sel < 90) begin
         raw = $urandom();
         return raw[15:0];
      end else if (sel < 95) begin
         return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      end
      walk_angle = 0;
      return 16'sd0;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_TARGET_SPEED:  cfg_target = longint'(val);
         CSR_MAX_WHEEL_VEL: cfg_maxvel = longint'(val);
         CSR_TURN_SCALE:    cfg_turn = longint'(val);
         CSR_REVERSE_DIR:   cfg_reverse = val[0];
         default: ;
      endcase
   endtask

   task automatic send_tick(input req_type it, input bit typed, input rsp_type want);
      rsp_type guess;
      csr_we <= 1'b0;
      while (!steady && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      guess = predict_wheels(it);
      pending_wheels.push_back(typed ? want : guess);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_wheels.size() != 0) @(posedge clock);
   endtask

   // result side: random backpressure and compare against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_wheels.size() == 0) begin
               $error("result item with nothing expected: left %0d right %0d",
                      rsp_data.left_velocity, rsp_data.right_velocity);
               mismatches++;
            end else begin
               want = pending_wheels.pop_front();
               if (rsp_data.left_velocity !== want.left_velocity) begin
                  $error("left_velocity expected %0d actual %0d",
                         want.left_velocity, rsp_data.left_velocity);
                  mismatches++;
               end
               if (rsp_data.right_velocity !== want.right_velocity) begin
                  $error("right_velocity expected %0d actual %0d",
                         want.right_velocity, rsp_data.right_velocity);
                  mismatches++;
               end
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= 30);
      end
   end

   // end the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      bit      prev_tick;
      int      stop_pct;
      req_type it;

      // reset settings
      plan.push_back(tick_row(KIND_DRIVE, 16'sd0));
      plan.push_back(typed_row(KIND_STOP, 16'sd0, 16'sd0, 16'sd0));
      plan.push_back(tick_row(KIND_DRIVE, 16'sh7FFF));
      plan.push_back(tick_row(KIND_DRIVE, 16'sh7FFF));
      plan.push_back(tick_row(KIND_DRIVE, 16'sh8000));
      plan.push_back(tick_row(KIND_DRIVE, 16'sh8000));
      // a stop ignores its angle
      plan.push_back(typed_row(KIND_STOP, 16'sh7FFF, 16'sd0, 16'sd0));
      plan.push_back(tick_row(KIND_DRIVE, 16'sd409));
      plan.push_back(tick_row(KIND_DRIVE, -16'sd410));
      plan.push_back(tick_row(KIND_DRIVE, 16'sd0));
      // everything at its top, forward, with a ramp restart
      plan.push_back(write_row(CSR_TARGET_SPEED, 16'hFFFF));
      plan.push_back(write_row(CSR_MAX_WHEEL_VEL, 16'hFFFF));
      plan.push_back(write_row(CSR_TURN_SCALE, 16'hFFFF));
      plan.push_back(write_row(CSR_REVERSE_DIR, 16'd0));
      plan.push_back(typed_row(KIND_STOP, 16'sd0, 16'sd0, 16'sd0));
      plan.push_back(tick_row(KIND_DRIVE, 16'sd0));
      plan.push_back(tick_row(KIND_DRIVE, 16'sh7FFF));
      plan.push_back(tick_row(KIND_DRIVE, 16'sh8000));
      // speed, velocity limit and turn scale at zero: both wheels stand still
      plan.push_back(write_row(CSR_TARGET_SPEED, 16'd0));
      plan.push_back(write_row(CSR_MAX_WHEEL_VEL, 16'd0));
      plan.push_back(write_row(CSR_TURN_SCALE, 16'd0));
      plan.push_back(write_row(CSR_REVERSE_DIR, 16'd1));
      plan.push_back(typed_row(KIND_DRIVE, 16'sh7FFF, 16'sd0, 16'sd0));
      plan.push_back(typed_row(KIND_DRIVE, 16'sh8000, 16'sd0, 16'sd0));
      // turn part alone, at full scale
      plan.push_back(write_row(CSR_TURN_SCALE, 16'hFFFF));
      plan.push_back(tick_row(KIND_DRIVE, 16'sh8000));
      plan.push_back(tick_row(KIND_DRIVE, 16'sh8000));
      plan.push_back(tick_row(KIND_DRIVE, 16'sh7FFF));
      plan.push_back(typed_row(KIND_STOP, 16'sd0, 16'sd0, 16'sd0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      prev_tick = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            if (prev_tick) drain_results();
            write_reg(plan[i].reg_idx, plan[i].reg_val);
            prev_tick = 1'b0;
         end else begin
            send_tick(plan[i].tick, plan[i].typed, plan[i].want);
            prev_tick = 1'b1;
         end
      end

      for (int ph = 0; ph < PhaseCount; ph++) begin
         drain_results();
         steady = (ph == 3);
         case ($urandom_range(7))
            0: write_reg(CSR_TARGET_SPEED, 16'd0);
            1: write_reg(CSR_TARGET_SPEED, 16'd32768);
            2: write_reg(CSR_TARGET_SPEED, 16'hFFFF);
            3: write_reg(CSR_TARGET_SPEED, 16'd16384);
            default: write_reg(CSR_TARGET_SPEED, 16'($urandom_range(32768)));
         endcase
         write_reg(CSR_MAX_WHEEL_VEL, pick_scale_reg(16'd2048));
         write_reg(CSR_TURN_SCALE, pick_scale_reg(16'd552));
         write_reg(CSR_REVERSE_DIR, 16'($urandom_range(1)));
         case ($urandom_range(2))
            0: stop_pct = 2;
            1: stop_pct = 10;
            default: stop_pct = 30;
         endcase
         for (int n = 0; n < PhaseItems; n++) begin
            it.kind = ($urandom_range(99) < stop_pct) ? KIND_STOP : KIND_DRIVE;
            it.line_angle = pick_angle();
            send_tick(it, 1'b0, '0);
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (24) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
